### sv/tkfk_pkg.sv
// ----------------------------------------------------------------------------
// tkfk_pkg
// Shared types, widths and codes for the top-K fitness keeper.
// ----------------------------------------------------------------------------
package tkfk_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int FIT_W       = 32;
	localparam int TAG_W       = 16;
	localparam int GEN_W       = 16;
	localparam int RANK_W      = 4;
	localparam int COUNT_W     = 5;
	localparam int LIMIT_W     = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT   = 1'b1;

	// Command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// One ranked list entry
	typedef struct packed {
		logic signed [FIT_W-1:0] fit;
		logic [TAG_W-1:0]        tag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_PLACE,
		ST_FETCH,
		ST_REPLY
	} state_t;

	// True when a is strictly better than b in the chosen direction
	function automatic logic better(input logic signed [FIT_W-1:0] a,
			input logic signed [FIT_W-1:0] b, input logic highest);
		return highest ? (a > b) : (a < b);
	endfunction

endpackage

### sv/top_k_fitness_keeper_unit.sv
// ----------------------------------------------------------------------------
// top_k_fitness_keeper_unit
// Sorted top-K candidate list held in one synchronous memory, plus best-ever
// fitness tracking. Inserts walk the list from the head, carrying displaced
// entries one rank down.
// ----------------------------------------------------------------------------
// Read command: busy through the fetch and reply states, done in the reply state.
// Insert: busy through the scan and shift (or place) states, then fetch and reply;
//   done in the reply state; the walk covers the entries held, clipped to the limit.
//   At most one memory read and one write per cycle; no new command while busy.
// Results are shown for one cycle on done; the receiver cannot stall.
// Reset clears the count, best-ever record and state, and sets the mode and limit
//   registers to defaults; the list memory is not cleared, ranks past the count read invalid.
module top_k_fitness_keeper_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Command channel
	input  logic                               start,
	output logic                               busy,
	input  logic                               cmd,
	input  logic signed [tkfk_pkg::FIT_W-1:0]  candidate_fitness,
	input  logic [tkfk_pkg::TAG_W-1:0]         candidate_id,
	input  logic [tkfk_pkg::GEN_W-1:0]         generation,
	input  logic [tkfk_pkg::RANK_W-1:0]        read_rank,
	// Result channel
	output logic                               done,
	output logic                               entry_valid,
	output logic signed [tkfk_pkg::FIT_W-1:0]  entry_fitness,
	output logic [tkfk_pkg::TAG_W-1:0]         entry_id,
	output logic [tkfk_pkg::COUNT_W-1:0]       entry_count,
	output logic                               best_valid,
	output logic signed [tkfk_pkg::FIT_W-1:0]  best_fitness,
	output logic [tkfk_pkg::GEN_W-1:0]         best_generation,
	// Configuration write port
	input  logic                               wr_en,
	input  logic [tkfk_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [tkfk_pkg::CFG_DATA_W-1:0]    wr_data
);
	import tkfk_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// List memory
	entry_t mem [MAX_ENTRIES];
	entry_t rd_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	entry_t        mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	state_t state_q, state_d;

	// Configuration
	logic               mode_q;
	logic [LIMIT_W-1:0] limit_q;

	// Command in flight
	logic                    cmd_q;
	logic signed [FIT_W-1:0] fit_q;
	logic [TAG_W-1:0]        tag_q;
	logic [GEN_W-1:0]        gen_q;
	logic [RANK_W-1:0]       rank_q;
	logic [CW-1:0]           lim_q;
	logic [CW-1:0]           n_q;
	logic [AW-1:0]           idx_q;
	entry_t                  carry_q;
	logic                    ent_valid_q;

	// List and best-ever state
	logic [CW-1:0]           held_q;
	logic signed [FIT_W-1:0] head_q;
	logic signed [FIT_W-1:0] best_fit_q;
	logic [GEN_W-1:0]        best_gen_q;
	logic                    best_seen_q;

	logic          accept;
	logic [CW-1:0] lim_now;
	logic [CW-1:0] n_eff;
	logic          cand_better;
	logic [CW-1:0] idx_nxt;
	logic [CW-1:0] last_idx;
	logic          more_held;
	logic          more_shift;
	logic          rank_ok;

	assign accept = start && (state_q == ST_IDLE);

	// Clip the configured limit to 1..MAX_ENTRIES
	always_comb begin
		if (limit_q == '0) begin
			lim_now = CW'(1);
		end else if (int'(limit_q) > MAX_ENTRIES) begin
			lim_now = CW'(MAX_ENTRIES);
		end else begin
			lim_now = CW'(limit_q);
		end
	end

	assign n_eff       = (held_q < lim_now) ? held_q : lim_now;
	assign cand_better = better(fit_q, rd_q.fit, mode_q);
	assign idx_nxt     = CW'(idx_q) + CW'(1);
	// lowest rank that receives an entry: one past the tail, or the tail when full
	assign last_idx    = (n_q < lim_q) ? n_q : lim_q - CW'(1);
	assign more_held   = idx_nxt < n_q;
	assign more_shift  = CW'(idx_q) < last_idx;
	assign rank_ok     = int'(rank_q) < int'(held_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd == CMD_READ) begin
						state_d = ST_FETCH;
					end else if (n_eff == '0) begin
						state_d = ST_PLACE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (cand_better) begin
					if (more_shift) begin
						state_d = ST_SHIFT;
					end else begin
						state_d = ST_FETCH;
					end
				end else if (!more_held) begin
					if (n_q < lim_q) begin
						state_d = ST_PLACE;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_SHIFT: begin
				if (!more_shift) begin
					state_d = ST_FETCH;
				end
			end
			ST_PLACE: state_d = ST_FETCH;
			ST_FETCH: state_d = ST_REPLY;
			ST_REPLY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory port control and handshake outputs
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = rd_q;
		mem_re = 1'b0;
		mem_ra = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && cmd == CMD_INSERT && n_eff != '0) begin
					mem_re = 1'b1;
					mem_ra = '0;
				end
			end
			ST_SCAN: begin
				// drop the candidate in front of the first entry it beats
				if (cand_better) begin
					mem_we     = 1'b1;
					mem_wa     = idx_q;
					mem_wd.fit = fit_q;
					mem_wd.tag = tag_q;
				end
				mem_re = more_held;
				mem_ra = AW'(idx_nxt);
			end
			ST_SHIFT: begin
				// move the carried entry one rank down, fetch the next one
				mem_we = 1'b1;
				mem_wa = idx_q;
				mem_wd = carry_q;
				mem_re = more_held;
				mem_ra = AW'(idx_nxt);
			end
			ST_PLACE: begin
				mem_we     = 1'b1;
				mem_wa     = idx_q;
				mem_wd.fit = fit_q;
				mem_wd.tag = tag_q;
			end
			ST_FETCH: begin
				mem_re = 1'b1;
				mem_ra = rank_ok ? AW'(rank_q) : '0;
			end
			ST_REPLY: begin
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_REPLY);

	assign entry_valid     = ent_valid_q;
	assign entry_fitness   = ent_valid_q ? rd_q.fit : '0;
	assign entry_id        = ent_valid_q ? rd_q.tag : '0;
	assign entry_count     = COUNT_W'(held_q);
	assign best_valid      = best_seen_q;
	assign best_fitness    = best_fit_q;
	assign best_generation = best_gen_q;

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			limit_q <= LIMIT_W'(16);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HIGHEST_MODE: mode_q  <= wr_data[0];
				REG_KEEP_LIMIT:   limit_q <= wr_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			best_fit_q  <= '0;
			best_gen_q  <= '0;
			best_seen_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// clip the count to the limit, and grow it unless the list is at its limit
			if (accept && cmd == CMD_INSERT) begin
				held_q <= (n_eff < lim_now) ? n_eff + CW'(1) : n_eff;
			end
			// take the head as best-ever when it beats the record
			if (state_q == ST_FETCH && cmd_q == CMD_INSERT &&
					(!best_seen_q || better(head_q, best_fit_q, mode_q))) begin
				best_fit_q  <= head_q;
				best_gen_q  <= gen_q;
				best_seen_q <= 1'b1;
			end
		end
	end

	// Command payload and walk position
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			fit_q  <= candidate_fitness;
			tag_q  <= candidate_id;
			gen_q  <= generation;
			rank_q <= read_rank;
			lim_q  <= lim_now;
			n_q    <= n_eff;
			idx_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			carry_q <= rd_q;
			if (cand_better && idx_q == '0) begin
				head_q <= fit_q;
			end
			// advance unless the walk ends on this entry
			if (!cand_better || more_shift) begin
				idx_q <= AW'(idx_nxt);
			end
		end
		if (state_q == ST_SHIFT) begin
			carry_q <= rd_q;
			if (more_shift) begin
				idx_q <= AW'(idx_nxt);
			end
		end
		if (state_q == ST_PLACE && idx_q == '0) begin
			head_q <= fit_q;
		end
		if (state_q == ST_FETCH) begin
			ent_valid_q <= rank_ok;
		end
	end

	// Checks
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(held_q) <= MAX_ENTRIES)
		else $error("held count exceeds list depth");

	a_done_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FETCH))
		else $error("result strobe without a preceding fetch");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted command did not raise busy");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_wa != mem_ra))
		else $error("read and write of the same entry in one cycle");

	a_valid_needs_entries: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid |-> (held_q != '0))
		else $error("valid entry reported from an empty list");

endmodule

### tb/top_k_fitness_keeper_unit_tb.sv
// ----------------------------------------------------------------------------
// top_k_fitness_keeper_unit_tb
// Self-checking bench for the top-K fitness keeper. A driver offers insert
// and read commands from a queue and keeps its own sorted list and best-ever
// record up to date as each transfer is accepted. A monitor checks every
// reported result against that list, field by field. The run goes through
// directed cases and then several phases of random traffic. Each phase
// writes a new direction and retention limit, out-of-range limits among
// them, with different amounts of sender idling.
// ----------------------------------------------------------------------------
module top_k_fitness_keeper_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import tkfk_pkg::*;

	localparam int LIST_DEPTH  = MAX_ENTRIES;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 8;

	typedef struct {
		logic                    cmd;
		logic signed [FIT_W-1:0] fit;
		logic [TAG_W-1:0]        id;
		logic [GEN_W-1:0]        gen;
		logic [RANK_W-1:0]       rank;
	} candidate_t;

	typedef struct {
		logic                    valid;
		logic signed [FIT_W-1:0] fit;
		logic [TAG_W-1:0]        id;
		logic [COUNT_W-1:0]      count;
		logic                    best_ok;
		logic signed [FIT_W-1:0] best_fit;
		logic [GEN_W-1:0]        best_gen;
	} keeper_report_t;

	logic                    clk;
	logic                    arst_n            = 1'b0;
	logic                    start             = 1'b0;
	logic                    busy;
	logic                    cmd               = CMD_INSERT;
	logic signed [FIT_W-1:0] candidate_fitness = '0;
	logic [TAG_W-1:0]        candidate_id      = '0;
	logic [GEN_W-1:0]        generation        = '0;
	logic [RANK_W-1:0]       read_rank         = '0;
	logic                    done;
	logic                    entry_valid;
	logic signed [FIT_W-1:0] entry_fitness;
	logic [TAG_W-1:0]        entry_id;
	logic [COUNT_W-1:0]      entry_count;
	logic                    best_valid;
	logic signed [FIT_W-1:0] best_fitness;
	logic [GEN_W-1:0]        best_generation;
	logic                    wr_en             = 1'b0;
	logic [CFG_IDX_W-1:0]    wr_index          = '0;
	logic [CFG_DATA_W-1:0]   wr_data           = '0;

	// Predicted state of the ranked list and the best-ever record
	logic signed [FIT_W-1:0] ranked_fit [LIST_DEPTH];
	logic [TAG_W-1:0]        ranked_tag [LIST_DEPTH];
	int                      kept_count     = 0;
	logic signed [FIT_W-1:0] best_fit_seen  = '0;
	logic [GEN_W-1:0]        best_gen_seen  = '0;
	logic                    any_inserted   = 1'b0;
	logic                    mode_reg       = 1'b1;
	logic [LIMIT_W-1:0]      limit_reg      = 5'd16;

	candidate_t     candidate_feed [$];
	keeper_report_t expected_reports [$];
	candidate_t     on_offer;
	keeper_report_t next_report;
	keeper_report_t want;
	int             queued_total    = 0;
	int             accepted_total  = 0;
	int             sender_idle_pct = 0;
	int             mismatch_count  = 0;
	int             stall_cycles    = 0;

	top_k_fitness_keeper_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cmd              (cmd),
		.candidate_fitness(candidate_fitness),
		.candidate_id     (candidate_id),
		.generation       (generation),
		.read_rank        (read_rank),
		.done             (done),
		.entry_valid      (entry_valid),
		.entry_fitness    (entry_fitness),
		.entry_id         (entry_id),
		.entry_count      (entry_count),
		.best_valid       (best_valid),
		.best_fitness     (best_fitness),
		.best_generation  (best_generation),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data)
	);

	// Clock: 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Strict ordering in the current direction
	function automatic logic outranks(input logic signed [FIT_W-1:0] a,
			input logic signed [FIT_W-1:0] b);
		return mode_reg ? (a > b) : (a < b);
	endfunction

	// Apply one command to the predicted list and form the report it causes
	task automatic keeper_apply(input candidate_t c, output keeper_report_t r);
		int lim;
		int n;
		int pos;
		lim = (limit_reg == 0) ? 1 : ((limit_reg > LIST_DEPTH) ? LIST_DEPTH : int'(limit_reg));
		if (c.cmd == CMD_INSERT) begin
			// drop entries beyond a lowered limit, then find the slot
			n = (kept_count > lim) ? lim : kept_count;
			pos = 0;
			while (pos < n && !outranks(c.fit, ranked_fit[pos]))
				pos++;
			if (pos < lim) begin
				for (int i = (n < lim) ? n : lim - 1; i > pos; i--) begin
					ranked_fit[i] = ranked_fit[i-1];
					ranked_tag[i] = ranked_tag[i-1];
				end
				ranked_fit[pos] = c.fit;
				ranked_tag[pos] = c.id;
				if (n < lim)
					n++;
			end
			kept_count = n;
			// the first insert always sets the best record
			if (!any_inserted || outranks(ranked_fit[0], best_fit_seen)) begin
				best_fit_seen = ranked_fit[0];
				best_gen_seen = c.gen;
				any_inserted  = 1'b1;
			end
		end
		r.valid    = c.rank < kept_count;
		r.fit      = r.valid ? ranked_fit[c.rank] : '0;
		r.id       = r.valid ? ranked_tag[c.rank] : '0;
		r.count    = kept_count[COUNT_W-1:0];
		r.best_ok  = any_inserted;
		r.best_fit = best_fit_seen;
		r.best_gen = best_gen_seen;
	endtask

	task automatic offer(input logic op, input logic signed [FIT_W-1:0] fit,
			input logic [TAG_W-1:0] id, input logic [GEN_W-1:0] gen,
			input logic [RANK_W-1:0] rank);
		candidate_t c;
		c.cmd  = op;
		c.fit  = fit;
		c.id   = id;
		c.gen  = gen;
		c.rank = rank;
		candidate_feed = {candidate_feed, c};
		queued_total++;
	endtask

	// Hold until every offered transfer is accepted and reported
	task automatic wait_quiet();
		while (accepted_total != queued_total || expected_reports.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic signed [63:0] exp_val,
			input logic signed [63:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatch_count++;
		end
	endtask

	// Driver: predict on each transfer, hold start while busy, idle at random
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				keeper_apply(on_offer, next_report);
				expected_reports = {expected_reports, next_report};
				accepted_total++;
			end
			if (!(start && busy)) begin
				if (candidate_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					on_offer = candidate_feed.pop_front();
					start             <= 1'b1;
					cmd               <= on_offer.cmd;
					candidate_fitness <= on_offer.fit;
					candidate_id      <= on_offer.id;
					generation        <= on_offer.gen;
					read_rank         <= on_offer.rank;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				$error("result strobed with no transfer pending");
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				check_field("entry_valid", 64'(want.valid), 64'(entry_valid));
				check_field("entry_fitness", 64'(want.fit), 64'(entry_fitness));
				check_field("entry_id", 64'(want.id), 64'(entry_id));
				check_field("entry_count", 64'(want.count), 64'(entry_count));
				check_field("best_valid", 64'(want.best_ok), 64'(best_valid));
				check_field("best_fitness", 64'(want.best_fit), 64'(best_fitness));
				check_field("best_generation", 64'(want.best_gen), 64'(best_generation));
			end
		end
	end

	// Watchdog: abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0]   mode_word;
		logic [LIMIT_W-1:0]      limit_word;
		logic                    phase_mode;
		int                      phase_idle;
		logic signed [FIT_W-1:0] fit;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			ranked_fit[i] = '0;
			ranked_tag[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, extremes, ties, filling and dropping at the tail
		offer(CMD_READ, 32'sh0, 16'h0, 16'h0, 4'd0);
		offer(CMD_READ, -32'sh1, 16'hFFFF, 16'hFFFF, 4'd15);
		offer(CMD_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 4'd0);
		offer(CMD_INSERT, 32'sh8000_0000, 16'h0000, 16'h0000, 4'd1);
		offer(CMD_INSERT, 32'sh0, 16'h1111, 16'h0002, 4'd2);
		offer(CMD_INSERT, 32'sh0, 16'h2222, 16'h0003, 4'd2);
		offer(CMD_INSERT, 32'sh7FFF_FFFF, 16'h3333, 16'h0004, 4'd1);
		offer(CMD_INSERT, -32'sh1, 16'h4444, 16'h0005, 4'd3);
		offer(CMD_INSERT, 32'sh1, 16'h5555, 16'h0006, 4'd4);
		offer(CMD_READ, 32'sh0, 16'h0, 16'h0, 4'd0);
		offer(CMD_READ, 32'sh0, 16'h0, 16'h0, 4'd2);
		offer(CMD_READ, 32'sh0, 16'h0, 16'h0, 4'd4);
		offer(CMD_READ, 32'sh0, 16'h0, 16'h0, 4'd15);
		for (int i = 0; i < 11; i++)
			offer(CMD_INSERT, 32'sh8000_0000, TAG_W'(32'hA000 + i), GEN_W'(32'h0100 + i),
				4'(i + 5));
		offer(CMD_INSERT, 32'sh4000_0000, 16'hBEEF, 16'h0200, 4'd15);
		offer(CMD_READ, 32'sh0, 16'h0, 16'h0, 4'd15);
		wait_quiet();

		// Random phases, each with its own direction, limit and idling
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin phase_mode = 1'b1; limit_word = 5'd16; phase_idle = 0;  end
				1: begin phase_mode = 1'b0; limit_word = 5'd16; phase_idle = 45; end
				2: begin phase_mode = 1'b0; limit_word = 5'd1;  phase_idle = 0;  end
				3: begin phase_mode = 1'b1; limit_word = 5'd0;  phase_idle = 15; end
				4: begin phase_mode = 1'b1; limit_word = 5'd31; phase_idle = 45; end
				5: begin phase_mode = 1'b0; limit_word = 5'd5;  phase_idle = 15; end
				6: begin phase_mode = 1'b1; limit_word = 5'd16; phase_idle = 0;  end
				default: begin phase_mode = 1'b0; limit_word = 5'd3; phase_idle = 45; end
			endcase
			// upper bits of the mode word are don't-care
			mode_word    = CFG_DATA_W'($urandom);
			mode_word[0] = phase_mode;
			@(posedge clk);
			wr_en    <= 1'b1;
			wr_index <= REG_HIGHEST_MODE;
			wr_data  <= mode_word;
			@(posedge clk);
			wr_index <= REG_KEEP_LIMIT;
			wr_data  <= limit_word;
			@(posedge clk);
			wr_en <= 1'b0;
			mode_reg        = phase_mode;
			limit_reg       = limit_word;
			sender_idle_pct = phase_idle;

			// read every rank first, so entries past a lowered limit are seen
			for (int r = 0; r < LIST_DEPTH; r++)
				offer(CMD_READ, $urandom, TAG_W'($urandom), GEN_W'($urandom), 4'(r));
			repeat (220) begin
				case ($urandom_range(7))
					0: begin
						case ($urandom_range(4))
							0: fit = 32'sh7FFF_FFFF;
							1: fit = 32'sh8000_0000;
							2: fit = 32'sh0;
							3: fit = -32'sh1;
							default: fit = 32'sh1;
						endcase
					end
					1, 2, 3: fit = $urandom_range(15) - 8;
					default: fit = $urandom;
				endcase
				offer(($urandom_range(9) < 7) ? CMD_INSERT : CMD_READ, fit,
					TAG_W'($urandom), GEN_W'($urandom), RANK_W'($urandom));
			end
			wait_quiet();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
